// ===== rtl/crr_pkg.sv =====
// shared types and codes for the copy map chain resolver
package crr_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_RECORD  = 2'd1,
        ACT_RESOLVE = 2'd2,
        ACT_LOOKUP  = 2'd3
    } crr_action_t;

    typedef struct packed {
        crr_action_t action;
        logic [11:0] dest_vreg;
        logic [9:0]  source_vreg;
        logic [7:0]  phi_entry_count;
        logic [11:0] query_vreg;
    } crr_in_t;

    typedef struct packed {
        logic [11:0] mapped_vreg;
        logic        any_copy;
    } crr_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RECORD,
        ST_RES_ISSUE,
        ST_RES_STEP,
        ST_LOOKUP,
        ST_RESP
    } crr_state_t;

    typedef struct packed {
        logic load_item;
        logic idx_clr;
        logic idx_inc;
        logic sweep_wr;
        logic clr_flag;
        logic rec_wr;
        logic res_start;
        logic res_issue;
        logic res_step;
        logic res_finish;
        logic lookup_rd;
        logic out_load;
    } crr_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic idx_done;
        logic step_end;
        logic out_free;
    } crr_status_t;

endpackage

// ===== rtl/crr_ram.sv =====
// generic single write port, single read port ram with registered read
module crr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/crr_datapath.sv =====
// rename table, chain walker registers, count register and result register
module crr_datapath import crr_pkg::*; #(
    parameter int MAX_VREGS   = 1024,
    parameter int CHAIN_LIMIT = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  crr_cmd_t    cmd,
    output crr_status_t status,
    input  crr_in_t     s_data,
    input  logic        cfg_valid,
    input  logic [10:0] cfg_vreg_count,
    output logic        m_valid,
    input  logic        m_ready,
    output crr_out_t    m_data
);

    localparam int AW      = $clog2(MAX_VREGS);
    localparam int ENTRY_W = (AW > 10) ? AW : 10;
    localparam int CNT_W   = $clog2(MAX_VREGS + 1);
    localparam int CMP_W   = (CNT_W > 12) ? CNT_W : 12;
    localparam int STEP_W  = $clog2(CHAIN_LIMIT + 1);

    logic [10:0]        vreg_count_reg, vreg_count_next;
    crr_in_t            item_reg, item_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [ENTRY_W-1:0] cur_reg, cur_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               any_reg, any_next;
    logic               flag_reg, flag_next;
    logic               m_valid_reg, m_valid_next;
    crr_out_t           m_data_reg, m_data_next;

    logic [CMP_W-1:0]   count_w, idx_ext, dest_ext, query_ext, rd_ext, end_ext;
    logic [ENTRY_W-1:0] rd_data, end_val;
    logic               chain_hit, limit_hit, next_out, step_end;
    logic               rec_ok, q_in_range;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data;

    crr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VREGS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // effective count saturates at the table depth
    assign count_w   = (CMP_W'(vreg_count_reg) > CMP_W'(MAX_VREGS)) ?
                       CMP_W'(MAX_VREGS) : CMP_W'(vreg_count_reg);
    assign idx_ext   = CMP_W'(idx_reg);
    assign dest_ext  = CMP_W'(item_reg.dest_vreg);
    assign query_ext = CMP_W'(item_reg.query_vreg);
    assign rd_ext    = CMP_W'(rd_data);

    assign chain_hit = (rd_data == cur_reg);
    assign limit_hit = (steps_reg == STEP_W'(CHAIN_LIMIT));
    assign next_out  = (rd_ext >= count_w);
    assign step_end  = chain_hit || limit_hit || next_out;
    assign end_val   = (chain_hit || limit_hit) ? cur_reg : rd_data;
    assign end_ext   = CMP_W'(end_val);

    assign rec_ok     = (item_reg.phi_entry_count == 8'd1) && (dest_ext < count_w);
    assign q_in_range = (query_ext < count_w);

    assign status.sweep_last = (idx_reg == CNT_W'(MAX_VREGS - 1));
    assign status.idx_done   = (idx_ext >= count_w);
    assign status.step_end   = step_end;
    assign status.out_free   = !m_valid_reg || m_ready;

    // table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = ENTRY_W'(idx_reg[AW-1:0]);
        if (cmd.sweep_wr) begin
            wr_en = 1'b1;
        end else if (cmd.rec_wr) begin
            wr_en   = rec_ok;
            wr_addr = dest_ext[AW-1:0];
            wr_data = ENTRY_W'(item_reg.source_vreg);
        end else if (cmd.res_step) begin
            wr_en   = step_end;
            wr_data = end_val;
        end
    end

    // table read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        if (cmd.res_issue) begin
            rd_en = 1'b1;
        end else if (cmd.res_step) begin
            rd_en   = !step_end;
            rd_addr = rd_data[AW-1:0];
        end else if (cmd.lookup_rd) begin
            rd_en   = 1'b1;
            rd_addr = query_ext[AW-1:0];
        end
    end

    always_comb begin
        vreg_count_next = cfg_valid ? cfg_vreg_count : vreg_count_reg;
        item_next       = cmd.load_item ? s_data : item_reg;

        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CNT_W'(1);
        end

        cur_next   = cur_reg;
        steps_next = steps_reg;
        if (cmd.res_issue) begin
            cur_next   = ENTRY_W'(idx_reg[AW-1:0]);
            steps_next = '0;
        end else if (cmd.res_step && !step_end) begin
            cur_next   = rd_data;
            steps_next = steps_reg + STEP_W'(1);
        end

        any_next = any_reg;
        if (cmd.res_start) begin
            any_next = 1'b0;
        end else if (cmd.res_step && step_end && (end_ext != idx_ext)) begin
            any_next = 1'b1;
        end

        flag_next = flag_reg;
        if (cmd.clr_flag) begin
            flag_next = 1'b0;
        end else if (cmd.res_finish) begin
            flag_next = any_reg;
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (cmd.out_load) begin
            m_valid_next         = 1'b1;
            m_data_next.any_copy = flag_reg;
            if (item_reg.action == ACT_LOOKUP) begin
                m_data_next.mapped_vreg = q_in_range ? rd_ext[11:0] : item_reg.query_vreg;
            end else begin
                m_data_next.mapped_vreg = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vreg_count_reg <= '0;
            idx_reg        <= '0;
            any_reg        <= 1'b0;
            flag_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            vreg_count_reg <= vreg_count_next;
            idx_reg        <= idx_next;
            any_reg        <= any_next;
            flag_reg       <= flag_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        steps_reg  <= steps_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/crr_ctrl.sv =====
// sequencing state machine for clear, record, resolve and lookup requests
module crr_ctrl import crr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  crr_action_t s_action,
    output logic        s_ready,
    output crr_cmd_t    cmd,
    input  crr_status_t status
);

    crr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    unique case (s_action)
                        ACT_CLEAR:   state_next = ST_CLEAR;
                        ACT_RECORD:  state_next = ST_RECORD;
                        ACT_RESOLVE: begin
                            cmd.res_start = 1'b1;
                            state_next    = ST_RES_ISSUE;
                        end
                        ACT_LOOKUP:  state_next = ST_LOOKUP;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.sweep_wr = 1'b1;
                cmd.clr_flag = 1'b1;
                if (status.sweep_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_RESP;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_RECORD: begin
                cmd.rec_wr = 1'b1;
                state_next = ST_RESP;
            end
            ST_RES_ISSUE: begin
                if (status.idx_done) begin
                    cmd.res_finish = 1'b1;
                    cmd.idx_clr    = 1'b1;
                    state_next     = ST_RESP;
                end else begin
                    cmd.res_issue = 1'b1;
                    state_next    = ST_RES_STEP;
                end
            end
            ST_RES_STEP: begin
                cmd.res_step = 1'b1;
                if (status.step_end) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_RES_ISSUE;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup_rd = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/copy_map_chain_resolver.sv =====
// copy map chain resolver top level
//
// Requests arrive on the s_ channel (valid/ready, one crr_in_t per request) and
// each gives exactly one crr_out_t on the m_ channel. vreg_count is written on
// the cfg channel, which is always ready; write it only while the block is idle.
// One request is worked on at a time; s_ready is high only in the idle state.
// Record does one table write and lookup one table read of the table ram; clear
// sweeps the ram one entry per cycle; resolve walks the chain of each entry
// below the count, each chain step being one ram read. The next request is taken
// in the cycle after the result is loaded.
// After reset the table is swept to identity with s_ready low; cfg writes are
// taken during this time. vreg_count resets to 0 and the copy flag to 0.
// A finished result waits in the output register while m_ready is low; the
// block returns to idle only once that register can take the new result.
module copy_map_chain_resolver import crr_pkg::*; #(
    parameter int MAX_VREGS   = 1024,
    parameter int CHAIN_LIMIT = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  crr_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output crr_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_vreg_count
);

    crr_cmd_t    cmd;
    crr_status_t status;

    assign cfg_ready = 1'b1;

    crr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_data.action),
        .s_ready  (s_ready),
        .cmd      (cmd),
        .status   (status)
    );

    crr_datapath #(
        .MAX_VREGS   (MAX_VREGS),
        .CHAIN_LIMIT (CHAIN_LIMIT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_data         (s_data),
        .cfg_valid      (cfg_valid),
        .cfg_vreg_count (cfg_vreg_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // result register is only loaded when free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result overwritten before it was taken");

    // only one source drives the table write port
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_wr |-> !(cmd.rec_wr || cmd.res_step))
        else $error("table write port conflict");

    // no request taken during a sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_wr |-> !s_ready)
        else $error("request taken during table sweep");

endmodule

// ===== verif/copy_map_chain_resolver_tb.sv =====
// testbench for the copy map chain resolver: rename scoreboard class and request drivers
module copy_map_chain_resolver_tb import crr_pkg::*; ();

    class rename_scoreboard;
        localparam int TABLE_SIZE  = 1024;
        localparam int CHAIN_STEPS = 100;

        logic [9:0]      entry [TABLE_SIZE];
        bit              copies_seen;
        logic [10:0]     vreg_count;
        crr_out_t        expected_results [$];
        int unsigned     mismatches;
        int unsigned     checked;
        int unsigned     action_hits [4];
        longint unsigned cycle_budget;

        function new();
            foreach (entry[i]) entry[i] = 10'(i);
            copies_seen  = 1'b0;
            vreg_count   = '0;
            mismatches   = 0;
            checked      = 0;
            cycle_budget = 0;
            foreach (action_hits[i]) action_hits[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void set_count(logic [10:0] value);
            vreg_count = value;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        // ascending walk over a table that is rewritten as it goes
        function bit resolve_chains(int unsigned live);
            int unsigned cur;
            int unsigned steps;
            bit          found;
            found = 1'b0;
            for (int unsigned i = 0; i < live; i++) begin
                cur   = i;
                steps = 0;
                while (cur < live && entry[cur] != cur && steps < CHAIN_STEPS) begin
                    cur = entry[cur];
                    steps++;
                end
                entry[i] = 10'(cur);
            end
            for (int unsigned i = 0; i < live; i++) begin
                if (entry[i] != i) found = 1'b1;
            end
            return found;
        endfunction

        function void note_request(crr_in_t req);
            int unsigned live;
            crr_out_t    want;
            live = (vreg_count > TABLE_SIZE) ? TABLE_SIZE : vreg_count;
            want = '0;
            action_hits[req.action]++;
            cycle_budget += 3 + 64;
            case (req.action)
                ACT_CLEAR: begin
                    foreach (entry[i]) entry[i] = 10'(i);
                    copies_seen = 1'b0;
                    cycle_budget += TABLE_SIZE + 2;
                end
                ACT_RECORD: begin
                    if (req.phi_entry_count == 8'd1 && req.dest_vreg < live)
                        entry[req.dest_vreg] = req.source_vreg;
                end
                ACT_RESOLVE: begin
                    copies_seen = resolve_chains(live);
                    cycle_budget += longint'(live) * (CHAIN_STEPS + 1) + 3;
                end
                default: begin
                    want.mapped_vreg = (req.query_vreg < live) ? 12'(entry[req.query_vreg])
                                                               : req.query_vreg;
                end
            endcase
            want.any_copy = copies_seen;
            expected_results.push_back(want);
        endfunction

        task check_result(crr_out_t got);
            crr_out_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with no request waiting: mapped_vreg=%0d any_copy=%0b",
                                 got.mapped_vreg, got.any_copy));
            end else begin
                want = expected_results.pop_front();
                if (got.mapped_vreg !== want.mapped_vreg)
                    report($sformatf("result %0d mapped_vreg got %0d want %0d",
                                     checked, got.mapped_vreg, want.mapped_vreg));
                if (got.any_copy !== want.any_copy)
                    report($sformatf("result %0d any_copy got %0b want %0b",
                                     checked, got.any_copy, want.any_copy));
                checked++;
            end
        endtask
    endclass

    localparam int MAX_VREGS    = 1024;
    localparam int CHAIN_LIMIT  = 100;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DIRECTED     = 24;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    crr_in_t     s_data         = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    crr_out_t    m_data;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_vreg_count = '0;

    rename_scoreboard sb = new();

    bit              calm           = 1'b0;
    logic [10:0]     stim_count     = '0;
    int unsigned     requests_sent  = 0;
    int unsigned     count_settings = 0;
    longint unsigned cycle_count    = 0;

    copy_map_chain_resolver #(
        .MAX_VREGS   (MAX_VREGS),
        .CHAIN_LIMIT (CHAIN_LIMIT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_vreg_count (cfg_vreg_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready <= calm || ($urandom_range(99) >= 8);
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_count(cfg_vreg_count);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_request(s_data);
        end
    end

    initial begin
        while (cycle_count <= 4 * sb.cycle_budget + 8 * MAX_VREGS + 50000) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned live_of(logic [10:0] c);
        return (c > MAX_VREGS) ? MAX_VREGS : c;
    endfunction

    function automatic crr_in_t make_request(crr_action_t act, int dest, int source, int phi,
                                             int query);
        crr_in_t r;
        r.action          = act;
        r.dest_vreg       = 12'(dest);
        r.source_vreg     = 10'(source);
        r.phi_entry_count = 8'(phi);
        r.query_vreg      = 12'(query);
        return r;
    endfunction

    // all fields random, then the ones that matter pulled into range when well formed
    function automatic crr_in_t build_request(crr_action_t act, bit well_formed);
        crr_in_t     r;
        int unsigned live;
        live = live_of(stim_count);
        r.action          = act;
        r.dest_vreg       = 12'($urandom_range(4095));
        r.source_vreg     = 10'($urandom_range(1023));
        r.phi_entry_count = 8'($urandom_range(255));
        r.query_vreg      = 12'($urandom_range(4095));
        if (well_formed && live > 0) begin
            case (act)
                ACT_RECORD: begin
                    r.phi_entry_count = 8'd1;
                    r.dest_vreg = 12'($urandom_range(live - 1));
                    if ($urandom_range(99) < 85) r.source_vreg = 10'($urandom_range(live - 1));
                end
                ACT_LOOKUP: r.query_vreg = 12'($urandom_range(live - 1));
                default: ;
            endcase
        end else if (act == ACT_RECORD && $urandom_range(1) == 0) begin
            r.phi_entry_count = 8'd1;
        end
        return r;
    endfunction

    task automatic send_request(input crr_in_t req);
        if (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_vreg_count(input logic [10:0] value);
        stim_count = value;
        count_settings++;
        cfg_valid      <= 1'b1;
        cfg_vreg_count <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mixed_phase();
        int unsigned n;
        int unsigned pick;
        crr_action_t act;
        n = $urandom_range(30, 70);
        if ($urandom_range(2) == 0) send_request(build_request(ACT_CLEAR, 1'b1));
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 3) act = ACT_CLEAR;
            else if (pick < 13) act = ACT_RESOLVE;
            else if (pick < 55) act = ACT_RECORD;
            else act = ACT_LOOKUP;
            send_request(build_request(act, $urandom_range(99) < 85));
        end
    endtask

    // table at or near full size: one resolve only, since each one walks every entry
    task automatic run_wide_phase();
        repeat (30)
            send_request(build_request($urandom_range(1) ? ACT_RECORD : ACT_LOOKUP,
                                       $urandom_range(99) < 85));
        send_request(build_request(ACT_RESOLVE, 1'b1));
        repeat (10) send_request(build_request(ACT_LOOKUP, $urandom_range(99) < 85));
    endtask

    // ascending chain longer than the step limit
    task automatic run_chain_phase();
        int unsigned len;
        len = live_of(stim_count);
        send_request(make_request(ACT_CLEAR, 0, 0, 0, 0));
        for (int unsigned i = 0; i + 1 < len; i++)
            send_request(make_request(ACT_RECORD, i, i + 1, 1, $urandom_range(4095)));
        send_request(build_request(ACT_RESOLVE, 1'b1));
        repeat (10) send_request(build_request(ACT_LOOKUP, 1'b1));
    endtask

    initial begin
        int unsigned phase;
        logic [10:0] wide_counts [4];
        wide_counts = '{11'd1023, 11'd1024, 11'd1025, 11'd2047};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: records ignored, lookups pass through
        write_vreg_count(11'd0);
        send_request(make_request(ACT_RECORD, 0, 5, 1, 0));
        send_request(make_request(ACT_RESOLVE, 0, 0, 0, 0));
        send_request(make_request(ACT_LOOKUP, 0, 0, 0, 0));
        send_request(make_request(ACT_LOOKUP, 4095, 1023, 255, 4095));
        drain_results();

        // two-entry cycle, chain leaving the range, rejected records
        write_vreg_count(11'd8);
        send_request(make_request(ACT_RECORD, 0, 1, 1, 0));
        send_request(make_request(ACT_RECORD, 1, 0, 1, 0));
        send_request(make_request(ACT_RECORD, 2, 7, 1, 0));
        send_request(make_request(ACT_RECORD, 7, 9, 1, 0));
        send_request(make_request(ACT_RECORD, 3, 5, 0, 0));
        send_request(make_request(ACT_RECORD, 4, 6, 255, 0));
        send_request(make_request(ACT_RECORD, 5, 6, 2, 0));
        send_request(make_request(ACT_RECORD, 8, 1, 1, 0));
        send_request(make_request(ACT_RECORD, 4095, 1023, 1, 0));
        send_request(make_request(ACT_RESOLVE, 0, 0, 0, 0));
        send_request(make_request(ACT_LOOKUP, 0, 0, 0, 0));
        send_request(make_request(ACT_LOOKUP, 0, 0, 0, 2));
        send_request(make_request(ACT_LOOKUP, 0, 0, 0, 7));
        send_request(make_request(ACT_LOOKUP, 0, 0, 0, 8));
        drain_results();

        // count above the table saturates, old entries kept across the change
        write_vreg_count(11'd2047);
        send_request(make_request(ACT_RECORD, 1023, 512, 1, 0));
        send_request(make_request(ACT_RECORD, 1024, 3, 1, 0));
        send_request(make_request(ACT_RESOLVE, 0, 0, 0, 0));
        send_request(make_request(ACT_LOOKUP, 0, 0, 0, 1023));
        send_request(make_request(ACT_LOOKUP, 0, 0, 0, 1024));
        send_request(make_request(ACT_CLEAR, 0, 0, 0, 0));

        phase = 0;
        while (requests_sent < DIRECTED + RANDOM_ITEMS) begin
            drain_results();
            calm = (phase >= 12 && phase < 17);
            case (phase % 12)
                5: write_vreg_count(wide_counts[$urandom_range(3)]);
                9: write_vreg_count(11'($urandom_range(110, 160)));
                default: begin
                    if ($urandom_range(9) == 0) write_vreg_count(11'($urandom_range(2)));
                    else write_vreg_count(11'($urandom_range(3, 48)));
                end
            endcase
            case (phase % 12)
                5: run_wide_phase();
                9: run_chain_phase();
                default: run_mixed_phase();
            endcase
            phase++;
        end
        drain_results();
        repeat (MAX_VREGS + 16) @(posedge aclk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d requests: %0d clear, %0d record, %0d resolve, %0d lookup",
                 requests_sent, sb.action_hits[ACT_CLEAR], sb.action_hits[ACT_RECORD],
                 sb.action_hits[ACT_RESOLVE], sb.action_hits[ACT_LOOKUP]);
        $display("%0d vreg_count settings over %0d phases, %0d results checked, %0d mismatches",
                 count_settings, phase, sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== copy_map_chain_resolver.f =====
rtl/crr_pkg.sv
rtl/crr_ram.sv
rtl/crr_datapath.sv
rtl/crr_ctrl.sv
rtl/copy_map_chain_resolver.sv
verif/copy_map_chain_resolver_tb.sv
